// File: src/vms_pkg.sv
package vms_pkg;

  // Motor drive codes
  typedef enum logic [1:0] {
    DRV_OFF  = 2'd0,
    DRV_FWD  = 2'd1,
    DRV_BACK = 2'd2
  } drive_e;

  // Move outcome codes
  typedef enum logic [3:0] {
    OC_NONE        = 4'd0,
    OC_REACHED     = 4'd1,
    OC_ALREADY     = 4'd2,
    OC_BOTH        = 4'd3,
    OC_DIRECTION   = 4'd4,
    OC_NOT_FOUND   = 4'd5,
    OC_OVERCURRENT = 4'd6,
    OC_BATTERY     = 4'd7,
    OC_STUCK       = 4'd8
  } outcome_e;

  // Item kind carried on tuser
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  // Register word indexes
  typedef enum logic [2:0] {
    REG_CURRENT_LIMIT   = 3'd0,
    REG_CURRENT_ERRORS  = 3'd1,
    REG_CURRENT_DELAY   = 3'd2,
    REG_BATTERY_EMPTY   = 3'd3,
    REG_BATTERY_PERIOD  = 3'd4,
    REG_MOVE_TIMEOUT    = 3'd5,
    REG_OVERSHOOT_A     = 3'd6,
    REG_OVERSHOOT_B     = 3'd7
  } reg_idx_e;

  // Register defaults
  localparam logic [11:0] CurrentLimitReset  = 12'd1500;
  localparam logic [3:0]  CurrentErrorsReset = 4'd3;
  localparam logic [9:0]  CurrentDelayReset  = 10'd50;
  localparam logic [12:0] BatteryEmptyReset  = 13'd3400;
  localparam logic [15:0] BatteryPeriodReset = 16'd100;
  localparam logic [12:0] MoveTimeoutReset   = 13'd4000;
  localparam logic [7:0]  OvershootAReset    = 8'd80;
  localparam logic [7:0]  OvershootBReset    = 8'd90;

  typedef struct packed {
    logic [11:0] current_limit_mv;
    logic [3:0]  current_error_limit;
    logic [9:0]  current_check_delay_ms;
    logic [12:0] battery_empty_mv;
    logic [15:0] battery_check_ms;
    logic [12:0] move_timeout_ms;
    logic [7:0]  overshoot_a;
    logic [7:0]  overshoot_b;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic        to_a;
    logic [3:0]  encoder_pulses;
    logic        at_a;
    logic        at_b;
    logic        direction_fault;
    logic [11:0] current_mv;
    logic [12:0] battery_mv;
    logic        external_power;
  } in_item_t;

  typedef struct packed {
    drive_e      drive;
    logic        finished;
    logic        success;
    outcome_e    outcome;
    logic [15:0] encoder_count;
    logic        battery_low;
    logic [12:0] battery_at_empty_mv;
  } out_item_t;

endpackage

// File: src/valve_move_supervisor.sv
// Path: a taken input beat is held in the input register, which feeds the step logic;
// its result lands in the result register when that register is free or draining.
// Throughput: one item per cycle unless m_tready stalls; the whole step is one pass of compare and counter logic.
// s_tready follows m_tready within the cycle when both registers hold a beat.
// Reset (rst, synchronous, active high) empties both registers, clears the move state
// and loads the register defaults.
module valve_move_supervisor
  import vms_pkg::*;
#(
  parameter int STUCK_PERIOD_MS  = 1000,
  parameter int LOW_SAMPLE_COUNT = 3,
  parameter int ENCODER_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // to_a, encoder_pulses[4], at_a, at_b, direction_fault, current_mv[12],
  // battery_mv[13], external_power, zero pad
  input  logic [39:0] s_tdata,
  // action
  input  logic        s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // drive[2], success, outcome[4], encoder_count[16], battery_low,
  // battery_at_empty_mv[13], zero pad
  output logic [39:0] m_tdata,
  // finished
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg;
  in_item_t  in_reg;
  logic      in_full;
  out_item_t step_res;
  out_item_t out_reg;
  logic      out_valid;
  logic      advance;

  vms_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vms_core #(
    .STUCK_PERIOD_MS  (STUCK_PERIOD_MS),
    .LOW_SAMPLE_COUNT (LOW_SAMPLE_COUNT),
    .ENCODER_BITS     (ENCODER_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_reg),
    .cfg  (cfg),
    .res  (step_res)
  );

  // Handshake: the held beat moves on when the result register is free or draining
  assign advance  = in_full && (!out_valid || m_tready);
  assign s_tready = !in_full || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_reg.action          <= s_tuser;
      in_reg.to_a            <= s_tdata[0];
      in_reg.encoder_pulses  <= s_tdata[4:1];
      in_reg.at_a            <= s_tdata[5];
      in_reg.at_b            <= s_tdata[6];
      in_reg.direction_fault <= s_tdata[7];
      in_reg.current_mv      <= s_tdata[19:8];
      in_reg.battery_mv      <= s_tdata[32:20];
      in_reg.external_power  <= s_tdata[33];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_reg.finished;
  assign m_tdata  = {3'd0, out_reg.battery_at_empty_mv, out_reg.battery_low,
                     out_reg.encoder_count, out_reg.outcome, out_reg.success,
                     out_reg.drive};

endmodule

// File: src/vms_cfg.sv
module vms_cfg
  import vms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.current_limit_mv       <= CurrentLimitReset;
      cfg.current_error_limit    <= CurrentErrorsReset;
      cfg.current_check_delay_ms <= CurrentDelayReset;
      cfg.battery_empty_mv       <= BatteryEmptyReset;
      cfg.battery_check_ms       <= BatteryPeriodReset;
      cfg.move_timeout_ms        <= MoveTimeoutReset;
      cfg.overshoot_a            <= OvershootAReset;
      cfg.overshoot_b            <= OvershootBReset;
    end else if (wr) begin
      case (idx)
        REG_CURRENT_LIMIT:  cfg.current_limit_mv       <= pwdata[11:0];
        REG_CURRENT_ERRORS: cfg.current_error_limit    <= pwdata[3:0];
        REG_CURRENT_DELAY:  cfg.current_check_delay_ms <= pwdata[9:0];
        REG_BATTERY_EMPTY:  cfg.battery_empty_mv       <= pwdata[12:0];
        REG_BATTERY_PERIOD: cfg.battery_check_ms       <= pwdata[15:0];
        REG_MOVE_TIMEOUT:   cfg.move_timeout_ms        <= pwdata[12:0];
        REG_OVERSHOOT_A:    cfg.overshoot_a            <= pwdata[7:0];
        REG_OVERSHOOT_B:    cfg.overshoot_b            <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_CURRENT_LIMIT:  prdata = {20'd0, cfg.current_limit_mv};
      REG_CURRENT_ERRORS: prdata = {28'd0, cfg.current_error_limit};
      REG_CURRENT_DELAY:  prdata = {22'd0, cfg.current_check_delay_ms};
      REG_BATTERY_EMPTY:  prdata = {19'd0, cfg.battery_empty_mv};
      REG_BATTERY_PERIOD: prdata = {16'd0, cfg.battery_check_ms};
      REG_MOVE_TIMEOUT:   prdata = {19'd0, cfg.move_timeout_ms};
      REG_OVERSHOOT_A:    prdata = {24'd0, cfg.overshoot_a};
      REG_OVERSHOOT_B:    prdata = {24'd0, cfg.overshoot_b};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// File: src/vms_core.sv
module vms_core
  import vms_pkg::*;
#(
  parameter int STUCK_PERIOD_MS  = 1000,
  parameter int LOW_SAMPLE_COUNT = 3,
  parameter int ENCODER_BITS     = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  localparam int EW = ENCODER_BITS;

  // Move state
  logic          running, running_next;
  logic          target_is_a, target_is_a_next;
  logic          sensor_seen, sensor_seen_next;
  logic [EW-1:0] enc_count, enc_count_next;
  logic          stop_count_valid, stop_count_valid_next;
  logic [EW:0]   stop_count, stop_count_next;
  logic [12:0]   elapsed_ms, elapsed_ms_next;
  logic [3:0]    overcurrent_run, overcurrent_run_next;
  logic [15:0]   battery_timer, battery_timer_next;
  logic [1:0]    battery_low_samples, battery_low_samples_next;
  logic          battery_low_flag, battery_low_flag_next;
  logic [12:0]   battery_empty_reading, battery_empty_reading_next;
  logic [9:0]    stuck_timer, stuck_timer_next;
  logic [EW-1:0] last_enc_count, last_enc_count_next;
  logic [1:0]    stuck_strikes, stuck_strikes_next;

  // Saturating encoder sum and timer increments
  logic [EW:0]   enc_sum;
  logic [EW-1:0] enc_sat;
  logic [15:0]   batt_tmr_inc;
  logic [9:0]    stuck_tmr_inc;
  logic          target_hit;
  logic [7:0]    overshoot;

  assign enc_sum       = {1'b0, enc_count} + (EW+1)'(item.encoder_pulses);
  assign enc_sat       = enc_sum[EW] ? {EW{1'b1}} : enc_sum[EW-1:0];
  assign batt_tmr_inc  = (battery_timer != 16'hFFFF) ? battery_timer + 16'd1 : battery_timer;
  assign stuck_tmr_inc = (stuck_timer != 10'h3FF) ? stuck_timer + 10'd1 : stuck_timer;
  assign target_hit    = target_is_a ? item.at_a : item.at_b;
  assign overshoot     = target_is_a ? cfg.overshoot_a : cfg.overshoot_b;

  // One item's step
  always_comb begin
    logic     ended;
    outcome_e oc;
    ended                      = 1'b0;
    oc                         = OC_NONE;
    running_next               = running;
    target_is_a_next           = target_is_a;
    sensor_seen_next           = sensor_seen;
    enc_count_next             = enc_count;
    stop_count_valid_next      = stop_count_valid;
    stop_count_next            = stop_count;
    elapsed_ms_next            = elapsed_ms;
    overcurrent_run_next       = overcurrent_run;
    battery_timer_next         = battery_timer;
    battery_low_samples_next   = battery_low_samples;
    battery_low_flag_next      = battery_low_flag;
    battery_empty_reading_next = battery_empty_reading;
    stuck_timer_next           = stuck_timer;
    last_enc_count_next        = last_enc_count;
    stuck_strikes_next         = stuck_strikes;
    res.drive                  = DRV_OFF;
    res.finished               = 1'b0;
    res.success                = 1'b0;

    if (item.action == ACT_START) begin
      if (running) begin
        // start while running: report status only
        res.drive = target_is_a ? DRV_BACK : DRV_FWD;
      end else begin
        sensor_seen_next         = 1'b0;
        stop_count_valid_next    = 1'b0;
        stop_count_next          = '0;
        enc_count_next           = '0;
        elapsed_ms_next          = '0;
        overcurrent_run_next     = '0;
        battery_timer_next       = '0;
        battery_low_samples_next = '0;
        battery_low_flag_next    = 1'b0;
        stuck_timer_next         = '0;
        last_enc_count_next      = '0;
        stuck_strikes_next       = '0;
        target_is_a_next         = item.to_a;
        if (item.at_a && item.at_b) begin
          res.finished = 1'b1;
          oc           = OC_BOTH;
        end else if ((item.to_a && item.at_a) || (!item.to_a && item.at_b)) begin
          res.finished = 1'b1;
          res.success  = 1'b1;
          oc           = OC_ALREADY;
        end else begin
          running_next = 1'b1;
          res.drive    = item.to_a ? DRV_BACK : DRV_FWD;
        end
      end
    end else if (running) begin
      enc_count_next = enc_sat;
      if (elapsed_ms != 13'h1FFF) elapsed_ms_next = elapsed_ms + 13'd1;

      // position reached
      if (!sensor_seen && target_hit) begin
        sensor_seen_next      = 1'b1;
        stop_count_next       = {1'b0, enc_sat} + (EW+1)'(overshoot);
        stop_count_valid_next = 1'b1;
      end

      if (stop_count_valid_next && ({1'b0, enc_sat} >= stop_count_next)) begin
        ended = 1'b1;
        oc    = OC_REACHED;
      end else if (item.direction_fault) begin
        ended = 1'b1;
        oc    = OC_DIRECTION;
      end else if (elapsed_ms_next >= cfg.move_timeout_ms) begin
        ended = 1'b1;
        oc    = battery_low_flag ? OC_BATTERY : OC_NOT_FOUND;
      end else begin
        // current supervision
        if (elapsed_ms_next >= {3'd0, cfg.current_check_delay_ms}) begin
          if (item.current_mv > cfg.current_limit_mv) begin
            if (overcurrent_run != 4'hF) overcurrent_run_next = overcurrent_run + 4'd1;
          end else begin
            overcurrent_run_next = '0;
          end
          if (overcurrent_run_next >= cfg.current_error_limit) begin
            ended = 1'b1;
            oc    = OC_OVERCURRENT;
          end
        end

        if (!ended) begin
          // battery sampling
          if (batt_tmr_inc >= cfg.battery_check_ms) begin
            battery_timer_next = '0;
            if (!item.external_power) begin
              if (item.battery_mv < cfg.battery_empty_mv) begin
                battery_empty_reading_next = item.battery_mv;
                if (battery_low_samples != 2'd3)
                  battery_low_samples_next = battery_low_samples + 2'd1;
              end
              if (battery_low_samples_next >= 2'(LOW_SAMPLE_COUNT))
                battery_low_flag_next = 1'b1;
            end
          end else begin
            battery_timer_next = batt_tmr_inc;
          end

          // stuck encoder supervision
          if (stuck_tmr_inc >= 10'(STUCK_PERIOD_MS)) begin
            stuck_timer_next = '0;
            if (last_enc_count == enc_sat) begin
              if (battery_low_flag_next) begin
                ended = 1'b1;
                oc    = OC_BATTERY;
              end else if (stuck_strikes < 2'(LOW_SAMPLE_COUNT)) begin
                stuck_strikes_next = stuck_strikes + 2'd1;
              end else begin
                stuck_strikes_next = '0;
                ended              = 1'b1;
                oc                 = OC_STUCK;
              end
            end else begin
              last_enc_count_next = enc_sat;
            end
          end else begin
            stuck_timer_next = stuck_tmr_inc;
          end
        end
      end

      if (ended) begin
        running_next = 1'b0;
        res.finished = 1'b1;
        res.success  = (oc == OC_REACHED);
      end else begin
        res.drive = target_is_a ? DRV_BACK : DRV_FWD;
      end
    end

    res.outcome             = oc;
    res.encoder_count       = 16'(enc_count_next);
    res.battery_low         = battery_low_flag_next;
    res.battery_at_empty_mv = battery_empty_reading_next;
  end

  // State update on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      running               <= 1'b0;
      target_is_a           <= 1'b0;
      sensor_seen           <= 1'b0;
      enc_count             <= '0;
      stop_count_valid      <= 1'b0;
      stop_count            <= '0;
      elapsed_ms            <= '0;
      overcurrent_run       <= '0;
      battery_timer         <= '0;
      battery_low_samples   <= '0;
      battery_low_flag      <= 1'b0;
      battery_empty_reading <= '0;
      stuck_timer           <= '0;
      last_enc_count        <= '0;
      stuck_strikes         <= '0;
    end else if (step) begin
      running               <= running_next;
      target_is_a           <= target_is_a_next;
      sensor_seen           <= sensor_seen_next;
      enc_count             <= enc_count_next;
      stop_count_valid      <= stop_count_valid_next;
      stop_count            <= stop_count_next;
      elapsed_ms            <= elapsed_ms_next;
      overcurrent_run       <= overcurrent_run_next;
      battery_timer         <= battery_timer_next;
      battery_low_samples   <= battery_low_samples_next;
      battery_low_flag      <= battery_low_flag_next;
      battery_empty_reading <= battery_empty_reading_next;
      stuck_timer           <= stuck_timer_next;
      last_enc_count        <= last_enc_count_next;
      stuck_strikes         <= stuck_strikes_next;
    end
  end

endmodule

// File: src/vms_checker.sv
module vms_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  // drive is never the unused code
  a_drive_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("drive carries an unused code");

  // a finishing beat never drives the motor
  a_finish_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[1:0] == 2'd0)
    else $error("finishing beat with motor driven");

  // an outcome is reported exactly on finishing beats
  a_outcome_fin: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[6:3] != 4'd0)))
    else $error("outcome and finished disagree");

  // success only for reached or already there
  a_success: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> (m_tdata[6:3] == 4'd1 || m_tdata[6:3] == 4'd2))
    else $error("success with a failing outcome");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

endmodule

bind valve_move_supervisor vms_checker u_vms_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: tb/valve_move_supervisor_tb.sv
`timescale 1ns / 1ps

module valve_move_supervisor_tb;
  import vms_pkg::*;

  localparam int StallPeriodMs  = 1000;
  localparam int LowSampleCount = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // to_a, encoder_pulses[4], at_a, at_b, direction_fault, current_mv[12],
  // battery_mv[13], external_power, zero pad
  logic [39:0] s_tdata = '0;
  // action
  logic        s_tuser = ACT_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // drive[2], success, outcome[4], encoder_count[16], battery_low,
  // battery_at_empty_mv[13], zero pad
  logic [39:0] m_tdata;
  // finished
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  valve_move_supervisor uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Register mirror and move state of the expected behaviour
  cfg_t        cfg;
  logic        mv_active, mv_to_a, mv_sensor_hit, mv_stop_armed;
  logic [15:0] mv_count;
  logic [16:0] mv_stop_at;
  logic [12:0] mv_ms;
  logic [3:0]  oc_run;
  logic [15:0] batt_tmr;
  logic [1:0]  batt_low_cnt;
  logic        batt_low;
  logic [12:0] batt_empty_seen;
  logic [9:0]  stall_tmr;
  logic [15:0] stall_ref;
  logic [1:0]  stall_strikes;

  out_item_t   pending_reports[$];
  out_item_t   report_head;
  int          errors = 0;
  int          send_gap_pct = 0;
  int          recv_gap_pct = 0;
  int          holds_asked = 0;
  int          holds_done = 0;
  int          hold_left = 0;

  function automatic out_item_t make_report(drive_e d, logic fin, logic ok, outcome_e oc);
    out_item_t r;
    r.drive = d;
    r.finished = fin;
    r.success = ok;
    r.outcome = oc;
    r.encoder_count = mv_count;
    r.battery_low = batt_low;
    r.battery_at_empty_mv = batt_empty_seen;
    return r;
  endfunction

  function automatic out_item_t finish_move(outcome_e oc);
    mv_active = 1'b0;
    return make_report(DRV_OFF, 1'b1, oc == OC_REACHED, oc);
  endfunction

  function automatic void clear_move();
    mv_sensor_hit = 1'b0;
    mv_stop_armed = 1'b0;
    mv_stop_at = '0;
    mv_count = '0;
    mv_ms = '0;
    oc_run = '0;
    batt_tmr = '0;
    batt_low_cnt = '0;
    batt_low = 1'b0;
    stall_tmr = '0;
    stall_ref = '0;
    stall_strikes = '0;
  endfunction

  // Expected result of one input beat; advances the mirrored move state
  function automatic out_item_t next_report(in_item_t it);
    logic [16:0] sum;
    drive_e      d;
    if (it.action == ACT_START) begin
      if (mv_active) return make_report(mv_to_a ? DRV_BACK : DRV_FWD, 1'b0, 1'b0, OC_NONE);
      clear_move();
      mv_to_a = it.to_a;
      if (it.at_a && it.at_b) return make_report(DRV_OFF, 1'b1, 1'b0, OC_BOTH);
      if ((it.to_a && it.at_a) || (!it.to_a && it.at_b))
        return make_report(DRV_OFF, 1'b1, 1'b1, OC_ALREADY);
      mv_active = 1'b1;
      return make_report(it.to_a ? DRV_BACK : DRV_FWD, 1'b0, 1'b0, OC_NONE);
    end
    if (!mv_active) return make_report(DRV_OFF, 1'b0, 1'b0, OC_NONE);
    d = mv_to_a ? DRV_BACK : DRV_FWD;

    sum = {1'b0, mv_count} + {13'd0, it.encoder_pulses};
    mv_count = sum[16] ? 16'hFFFF : sum[15:0];
    if (mv_ms != 13'h1FFF) mv_ms++;

    // target sensor arms the overshoot stop once
    if (!mv_sensor_hit && ((mv_to_a && it.at_a) || (!mv_to_a && it.at_b))) begin
      mv_sensor_hit = 1'b1;
      mv_stop_at = {1'b0, mv_count} + {9'd0, mv_to_a ? cfg.overshoot_a : cfg.overshoot_b};
      mv_stop_armed = 1'b1;
    end
    if (mv_stop_armed && {1'b0, mv_count} >= mv_stop_at) return finish_move(OC_REACHED);
    if (it.direction_fault) return finish_move(OC_DIRECTION);
    if (mv_ms >= cfg.move_timeout_ms) return finish_move(batt_low ? OC_BATTERY : OC_NOT_FOUND);

    // current supervision after the start-up delay
    if (mv_ms >= cfg.current_check_delay_ms) begin
      if (it.current_mv > cfg.current_limit_mv) begin
        if (oc_run != 4'hF) oc_run++;
      end else begin
        oc_run = '0;
      end
      if (oc_run >= cfg.current_error_limit) return finish_move(OC_OVERCURRENT);
    end

    // periodic battery sample, never stops the move itself
    if (batt_tmr != 16'hFFFF) batt_tmr++;
    if (batt_tmr >= cfg.battery_check_ms) begin
      batt_tmr = '0;
      if (!it.external_power) begin
        if (it.battery_mv < cfg.battery_empty_mv) begin
          batt_empty_seen = it.battery_mv;
          if (batt_low_cnt != 2'd3) batt_low_cnt++;
        end
        if (batt_low_cnt >= LowSampleCount) batt_low = 1'b1;
      end
    end

    // stuck encoder: strikes on unchanged samples, then stop
    if (stall_tmr != 10'h3FF) stall_tmr++;
    if (stall_tmr >= StallPeriodMs) begin
      stall_tmr = '0;
      if (stall_ref == mv_count) begin
        if (batt_low) return finish_move(OC_BATTERY);
        if (stall_strikes < LowSampleCount) begin
          stall_strikes++;
        end else begin
          stall_strikes = '0;
          return finish_move(OC_STUCK);
        end
      end else begin
        stall_ref = mv_count;
      end
    end
    return make_report(d, 1'b0, 1'b0, OC_NONE);
  endfunction

  function automatic in_item_t make_beat(logic act, logic to_a, logic [3:0] pulses,
                                         logic a, logic b, logic dir_fault,
                                         logic [11:0] cur, logic [12:0] batt, logic ext);
    return '{act, to_a, pulses, a, b, dir_fault, cur, batt, ext};
  endfunction

  function automatic int near(int centre, int spread, int top);
    int v;
    v = centre + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  function automatic logic [31:0] reg_of(cfg_t c, reg_idx_e r);
    case (r)
      REG_CURRENT_LIMIT:  return 32'(c.current_limit_mv);
      REG_CURRENT_ERRORS: return 32'(c.current_error_limit);
      REG_CURRENT_DELAY:  return 32'(c.current_check_delay_ms);
      REG_BATTERY_EMPTY:  return 32'(c.battery_empty_mv);
      REG_BATTERY_PERIOD: return 32'(c.battery_check_ms);
      REG_MOVE_TIMEOUT:   return 32'(c.move_timeout_ms);
      REG_OVERSHOOT_A:    return 32'(c.overshoot_a);
      default:            return 32'(c.overshoot_b);
    endcase
  endfunction

  task automatic chk_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // APB write: setup then access phase
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CURRENT_LIMIT:  cfg.current_limit_mv = val[11:0];
      REG_CURRENT_ERRORS: cfg.current_error_limit = val[3:0];
      REG_CURRENT_DELAY:  cfg.current_check_delay_ms = val[9:0];
      REG_BATTERY_EMPTY:  cfg.battery_empty_mv = val[12:0];
      REG_BATTERY_PERIOD: cfg.battery_check_ms = val[15:0];
      REG_MOVE_TIMEOUT:   cfg.move_timeout_ms = val[12:0];
      REG_OVERSHOOT_A:    cfg.overshoot_a = val[7:0];
      default:            cfg.overshoot_b = val[7:0];
    endcase
  endtask

  task automatic read_reg(reg_idx_e idx, output logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    val = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_config(cfg_t c);
    for (int i = 0; i < 8; i++) write_reg(reg_idx_e'(i), reg_of(c, reg_idx_e'(i)));
  endtask

  // Offer one beat, with an optional idle gap first; predict on acceptance
  task automatic send_beat(in_item_t it);
    int gap;
    gap = ($urandom_range(99) < send_gap_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    while (gap > 0) begin
      s_tvalid <= 1'b0;
      gap--;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.action;
    s_tdata <= {6'd0, it.external_power, it.battery_mv, it.current_mv, it.direction_fault,
                it.at_b, it.at_a, it.encoder_pulses, it.to_a};
    do @(posedge clk); while (!s_tready);
    pending_reports.push_back(next_report(it));
  endtask

  // Stop offering and let every outstanding result come back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off when one is asked for
  always @(negedge clk) begin
    if (holds_asked != holds_done) begin
      holds_done = holds_asked;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, m_tdata);
        errors++;
      end else begin
        report_head = pending_reports.pop_front();
        chk_field("drive", report_head.drive, m_tdata[1:0]);
        chk_field("success", report_head.success, m_tdata[2]);
        chk_field("outcome", report_head.outcome, m_tdata[6:3]);
        chk_field("encoder_count", report_head.encoder_count, m_tdata[22:7]);
        chk_field("battery_low", report_head.battery_low, m_tdata[23]);
        chk_field("battery_at_empty_mv", report_head.battery_at_empty_mv, m_tdata[36:24]);
        chk_field("pad", 32'd0, m_tdata[39:37]);
        chk_field("finished", report_head.finished, m_tlast);
      end
    end
  end

  // Reset values, then a write and read back of every register
  task automatic test_registers();
    logic [31:0] got;
    cfg_t        c;
    for (int i = 0; i < 8; i++) begin
      read_reg(reg_idx_e'(i), got);
      chk_field($sformatf("reset value of reg %0d", i), reg_of(cfg, reg_idx_e'(i)), got);
    end
    c = '{12'hA5A, 4'd9, 10'h2B6, 13'h15AA, 16'hA5A5, 13'h0A55, 8'h5A, 8'hA5};
    apply_config(c);
    for (int i = 0; i < 8; i++) begin
      read_reg(reg_idx_e'(i), got);
      chk_field($sformatf("read back of reg %0d", i), reg_of(cfg, reg_idx_e'(i)), got);
    end
  endtask

  // Immediate outcomes, start while running, idle tick and each way a move ends but a stuck encoder
  task automatic test_directed();
    drain();
    apply_config('{CurrentLimitReset, CurrentErrorsReset, CurrentDelayReset,
                   BatteryEmptyReset, BatteryPeriodReset, MoveTimeoutReset,
                   OvershootAReset, OvershootBReset});
    send_beat(make_beat(ACT_TICK, 1'b1, 4'hF, 1'b1, 1'b1, 1'b1, 12'hFFF, 13'h1FFF, 1'b1));
    send_beat(make_beat(ACT_START, 1'b1, 4'd0, 1'b1, 1'b1, 1'b0, 12'd0, 13'd0, 1'b0));
    send_beat(make_beat(ACT_START, 1'b1, 4'd0, 1'b1, 1'b0, 1'b0, 12'd0, 13'd0, 1'b0));
    send_beat(make_beat(ACT_START, 1'b0, 4'd0, 1'b0, 1'b1, 1'b0, 12'd0, 13'd0, 1'b0));
    send_beat(make_beat(ACT_START, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0, 1'b0));
    send_beat(make_beat(ACT_START, 1'b1, 4'd0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0, 1'b0));
    send_beat(make_beat(ACT_TICK, 1'b0, 4'hF, 1'b0, 1'b0, 1'b0, 12'hFFF, 13'd0, 1'b1));
    send_beat(make_beat(ACT_TICK, 1'b0, 4'hF, 1'b0, 1'b1, 1'b0, 12'd0, 13'h1FFF, 1'b0));
    send_beat(make_beat(ACT_TICK, 1'b0, 4'd3, 1'b0, 1'b1, 1'b1, 12'd0, 13'd0, 1'b0));

    // lowest settings: timeout on the first tick, zero overshoot
    drain();
    apply_config('{12'd0, 4'd1, 10'd0, 13'd0, 16'd1, 13'd1, 8'd0, 8'd0});
    send_beat(make_beat(ACT_START, 1'b1, 4'd0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0, 1'b0));
    send_beat(make_beat(ACT_TICK, 1'b0, 4'd5, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0, 1'b0));
    send_beat(make_beat(ACT_START, 1'b1, 4'd0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0, 1'b0));
    send_beat(make_beat(ACT_TICK, 1'b0, 4'd0, 1'b1, 1'b0, 1'b0, 12'd0, 13'd0, 1'b0));

    // overcurrent at once, then timeout with battery low confirmed
    drain();
    apply_config('{12'd0, 4'd1, 10'd0, 13'h1FFF, 16'd1, 13'd4, 8'hFF, 8'hFF});
    send_beat(make_beat(ACT_START, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0, 1'b0));
    send_beat(make_beat(ACT_TICK, 1'b0, 4'd1, 1'b0, 1'b0, 1'b0, 12'd1, 13'd0, 1'b1));
    send_beat(make_beat(ACT_START, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0, 1'b0));
    repeat (4)
      send_beat(make_beat(ACT_TICK, 1'b0, 4'd2, 1'b0, 1'b0, 1'b0, 12'd0, 13'd100, 1'b0));
  endtask

  // Long moves: stuck encoder, full timeout, encoder saturation with low battery
  task automatic test_long_moves();
    drain();
    apply_config('{12'hFFF, 4'd15, 10'h3FF, 13'd3400, 16'hFFFF, 13'h1FFF, 8'd80, 8'd90});
    send_beat(make_beat(ACT_START, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0, 1'b0));
    while (mv_active)
      send_beat(make_beat(ACT_TICK, 1'($urandom), 4'd0, 1'b0, 1'b0, 1'b0, 12'($urandom),
                          13'($urandom), 1'($urandom)));
    send_beat(make_beat(ACT_START, 1'b1, 4'd0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0, 1'b0));
    while (mv_active)
      send_beat(make_beat(ACT_TICK, 1'b0, 4'($urandom_range(1, 2)), 1'b0, 1'b0, 1'b0,
                          12'($urandom), 13'($urandom), 1'($urandom)));

    drain();
    apply_config('{12'hFFF, 4'd15, 10'h3FF, 13'h1FFF, 16'd1, 13'h1FFF, 8'd80, 8'd90});
    send_beat(make_beat(ACT_START, 1'b1, 4'd0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0, 1'b0));
    while (mv_active)
      send_beat(make_beat(ACT_TICK, 1'b0, 4'hF, 1'b0, 1'b0, 1'b0, 12'($urandom),
                          13'($urandom_range(0, 8190)), 1'b0));
  endtask

  // Mostly whole moves with random content, some noise beats
  task automatic test_random_moves(int n_items, bit use_max);
    cfg_t        c;
    in_item_t    it;
    int          sent;
    int          r;
    logic        tgt, hit, other;
    logic [11:0] cur;
    logic [12:0] batt;
    drain();
    if (use_max) begin
      c = '{12'hFFF, 4'd15, 10'h3FF, 13'h1FFF, 16'hFFFF, 13'h1FFF, 8'hFF, 8'hFF};
    end else begin
      c.current_limit_mv = 12'($urandom);
      c.current_error_limit = ($urandom_range(99) < 70) ? 4'($urandom_range(1, 4))
                                                        : 4'($urandom_range(1, 15));
      c.current_check_delay_ms = ($urandom_range(99) < 80) ? 10'($urandom_range(0, 20))
                                                           : 10'($urandom_range(0, 1023));
      c.battery_empty_mv = 13'($urandom);
      c.battery_check_ms = ($urandom_range(99) < 80) ? 16'($urandom_range(1, 8))
                                                     : 16'($urandom_range(1, 65535));
      c.move_timeout_ms = ($urandom_range(99) < 85) ? 13'($urandom_range(5, 200))
                                                    : 13'($urandom_range(1, 8191));
      c.overshoot_a = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 30)) : 8'($urandom);
      c.overshoot_b = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 30)) : 8'($urandom);
    end
    apply_config(c);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        // noise beat; idle ticks do not count
        it = in_item_t'(35'({$urandom, $urandom}));
        if (it.action == ACT_START || mv_active) sent++;
        send_beat(it);
      end else begin
        tgt = 1'($urandom);
        r = $urandom_range(99);
        send_beat(make_beat(ACT_START, tgt, 4'($urandom), (r >= 80) & 1'($urandom),
                            (r >= 80) & 1'($urandom), 1'($urandom), 12'($urandom),
                            13'($urandom), 1'($urandom)));
        sent++;
        while (mv_active) begin
          if ($urandom_range(99) < 4) begin
            it = make_beat(ACT_START, 1'($urandom), 4'($urandom), 1'($urandom),
                           1'($urandom), 1'($urandom), 12'($urandom), 13'($urandom),
                           1'($urandom));
          end else begin
            hit = ($urandom_range(99) < 6);
            other = ($urandom_range(99) < 10);
            r = $urandom_range(99);
            if (r < 30) cur = 12'($urandom);
            else if (r < 60) cur = 12'(near(int'(cfg.current_limit_mv), 40, 4095));
            else cur = 12'($urandom_range(0, cfg.current_limit_mv));
            batt = ($urandom_range(99) < 50) ? 13'($urandom)
                                             : 13'(near(int'(cfg.battery_empty_mv), 300, 8191));
            it = make_beat(ACT_TICK, 1'($urandom), 4'($urandom), tgt ? hit : other,
                           tgt ? other : hit, ($urandom_range(59) == 0), cur, batt,
                           ($urandom_range(99) < 25));
          end
          send_beat(it);
          sent++;
        end
      end
    end
    // end any move a noise start left running
    while (mv_active)
      send_beat(make_beat(ACT_TICK, 1'b0, 4'd0, 1'b0, 1'b0, 1'b1, 12'd0, 13'd0, 1'b1));
  endtask

  initial begin
    cfg = '{CurrentLimitReset, CurrentErrorsReset, CurrentDelayReset, BatteryEmptyReset,
            BatteryPeriodReset, MoveTimeoutReset, OvershootAReset, OvershootBReset};
    mv_active = 1'b0;
    mv_to_a = 1'b0;
    batt_empty_seen = '0;
    clear_move();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_gap_pct = 18;
    recv_gap_pct = 49;
    test_registers();
    test_directed();
    test_long_moves();
    test_random_moves(400, 1'b0);

    // long hold-off starts once the block is empty, so new beats pile up behind it
    drain();
    send_gap_pct = 49;
    recv_gap_pct = 18;
    holds_asked++;
    test_random_moves(400, 1'b0);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_moves(150, 1'b1);
    test_random_moves(250, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
